// ===== rtl/trailing_moving_average_assert.svh =====
// Assertion macros for the trailing moving average block.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef TRAILING_MOVING_AVERAGE_ASSERT_SVH
`define TRAILING_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TMA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TMA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tma_pkg.sv =====
// Shared types, widths and helper functions of the trailing moving average block.
// No dependencies; imported by every module of the block.
`default_nettype none

package tma_pkg;

	// Ring depth and the widths that follow from it.
	localparam int MAX_WINDOW = 256;
	localparam int VALUE_W = 32;
	localparam int CFG_W = 9;
	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(7);
	localparam int SLOT_W = $clog2(MAX_WINDOW);
	localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = VALUE_W + SLOT_W;
	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam int WIDE_W = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// How the back updates the running sum for one item.
	typedef enum logic [1:0] {
		OP_START,  // sum is the new total alone
		OP_GROW,   // window grew by one: add the new total
		OP_SLIDE,  // same window: add the new total, drop the oldest
		OP_RESUM   // window size changed: sum the ring again
	} op_t;

	// One classified beat as it travels from the front to the back.
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] rd_addr;
		logic [COUNT_W-1:0] count;
		op_t op;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// Ring slot that lies gap places behind slot, wrapping at the ring depth.
	function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] slot,
		input logic [COUNT_W-1:0] gap);
		logic [COUNT_W-1:0] s;
		logic [COUNT_W-1:0] r;
		s = COUNT_W'(slot);
		if (s >= gap) begin
			r = s - gap;
		end else begin
			r = COUNT_W'(MAX_WINDOW) - (gap - s);
		end
		return r[SLOT_W-1:0];
	endfunction

	// Sign extension of one daily total to the width of the running sum.
	function automatic logic signed [SUM_W-1:0] ext_total(input logic [VALUE_W-1:0] v);
		return {{(SUM_W - VALUE_W){v[VALUE_W-1]}}, v};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tma_queue.sv =====
// Short queue that decouples the front from the back.
// Depends on tma_pkg for the item type and the queue depth.
`default_nettype none

module tma_queue
	import tma_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire item_t push_item,
	input wire logic pop,
	output item_t head,
	output q_status_t status
);

	item_t entries [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Pointer advance with wrap at the queue depth.
	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Storage for queued beats; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head = entries[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full = (count_q == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ===== rtl/tma_front.sv =====
// Front of the block: takes input beats and the window size register, tracks
// fill count and ring slot, and classifies how each beat updates the sum.
// Depends on tma_pkg.
`default_nettype none

module tma_front
	import tma_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [VALUE_W-1:0] day_revenue,
	input wire logic starts_series,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_W-1:0] cfg_data,
	input wire q_status_t q_status,
	output logic push,
	output item_t push_item
);

	logic [CFG_W-1:0] window_size_q;
	logic [COUNT_W-1:0] fill_q;
	logic [SLOT_W-1:0] slot_q;
	logic [COUNT_W-1:0] nprev_q;

	logic [COUNT_W-1:0] fill_base;
	logic [SLOT_W-1:0] slot_base;
	logic [COUNT_W-1:0] nprev_base;
	logic [COUNT_W-1:0] fill_new;
	logic [WIDE_W-1:0] ws_wide;
	logic [WIDE_W-1:0] w_wide;
	logic [COUNT_W-1:0] w_eff;
	logic [COUNT_W-1:0] count;
	logic [SLOT_W-1:0] slot_next;
	op_t op;

	assign in_ready = !q_status.full;
	assign push = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// A series start sees an empty window.
	assign fill_base = starts_series ? '0 : fill_q;
	assign slot_base = starts_series ? '0 : slot_q;
	assign nprev_base = starts_series ? '0 : nprev_q;

	// Fill count after this beat, saturating at the ring depth.
	assign fill_new = (fill_base == COUNT_W'(MAX_WINDOW)) ? fill_base : fill_base + 1'b1;

	// Effective window size: zero reads as one, large values clamp to the ring depth.
	assign ws_wide = WIDE_W'(window_size_q);
	always_comb begin
		if (ws_wide == '0) begin
			w_wide = WIDE_W'(1);
		end else if (ws_wide > WIDE_W'(MAX_WINDOW)) begin
			w_wide = WIDE_W'(MAX_WINDOW);
		end else begin
			w_wide = ws_wide;
		end
	end
	assign w_eff = w_wide[COUNT_W-1:0];
	assign count = (fill_new < w_eff) ? fill_new : w_eff;

	// Classify the sum update against the window of the previous beat.
	always_comb begin
		if (starts_series || count == COUNT_W'(1)) begin
			op = OP_START;
		end else if ({1'b0, count} == {1'b0, nprev_base} + 1'b1) begin
			op = OP_GROW;
		end else if (count == nprev_base) begin
			op = OP_SLIDE;
		end else begin
			op = OP_RESUM;
		end
	end

	assign slot_next = (slot_base == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_base + 1'b1;

	// Beat handed to the queue; the first ring read depends on the update kind.
	always_comb begin
		push_item.value = day_revenue;
		push_item.slot = slot_base;
		push_item.count = count;
		push_item.op = op;
		if (op == OP_SLIDE) begin
			push_item.rd_addr = slot_back(slot_base, count);
		end else begin
			push_item.rd_addr = slot_back(slot_base, COUNT_W'(1));
		end
	end

	// Series tracking and the window size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_RESET;
			fill_q <= '0;
			slot_q <= '0;
			nprev_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_size_q <= cfg_data;
			end
			if (push) begin
				fill_q <= fill_new;
				slot_q <= slot_next;
				nprev_q <= count;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tma_back.sv =====
// Back of the block: holds the ring of recent totals and the running sum,
// divides the sum by the window count and drives the output register.
// Depends on tma_pkg.
`default_nettype none

module tma_back
	import tma_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire q_status_t q_status,
	input wire item_t head,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [VALUE_W-1:0] window_mean
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DROP,
		ST_ACCUM,
		ST_SIGN,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	item_t cur_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SLOT_W-1:0] addr_q;
	logic [COUNT_W-1:0] left_q;
	logic [SUM_W-1:0] quo_q;
	logic [COUNT_W-1:0] rem_q;
	logic neg_q;
	logic [STEP_W-1:0] step_q;
	logic out_valid_q;
	logic signed [VALUE_W-1:0] mean_q;

	logic [VALUE_W-1:0] ring [MAX_WINDOW];
	logic [VALUE_W-1:0] rd_data_q;
	logic [SLOT_W-1:0] rd_addr;
	logic ring_wr;

	logic [COUNT_W:0] shifted;
	logic [COUNT_W:0] diff;
	logic ge;
	logic [SUM_W-1:0] result;
	logic fin_take;

	assign pop = (state_q == ST_IDLE) && !q_status.empty;

	// Ring port: the new total goes in while the first old entry is read.
	assign ring_wr = (state_q == ST_PREP);
	assign rd_addr = (state_q == ST_PREP) ? cur_q.rd_addr : addr_q;

	always_ff @(posedge clk) begin
		if (ring_wr) begin
			ring[cur_q.slot] <= cur_q.value;
		end
		rd_data_q <= ring[rd_addr];
	end

	// One restoring division step.
	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign ge = (shifted >= {1'b0, cur_q.count});
	assign diff = shifted - {1'b0, cur_q.count};
	assign result = neg_q ? (~quo_q + 1'b1) : quo_q;

	// The finished mean moves to the output register once that register is free.
	assign fin_take = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// Sequencer: sum update, sign split, division and result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q <= '0;
			sum_q <= '0;
			addr_q <= '0;
			left_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			neg_q <= 1'b0;
			step_q <= '0;
			out_valid_q <= 1'b0;
			mean_q <= '0;
		end else begin
			if (fin_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cur_q <= head;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					unique case (cur_q.op)
						OP_START: begin
							sum_q <= ext_total(cur_q.value);
							state_q <= ST_SIGN;
						end
						OP_GROW: begin
							sum_q <= sum_q + ext_total(cur_q.value);
							state_q <= ST_SIGN;
						end
						OP_SLIDE: begin
							sum_q <= sum_q + ext_total(cur_q.value);
							state_q <= ST_DROP;
						end
						OP_RESUM: begin
							sum_q <= ext_total(cur_q.value);
							addr_q <= slot_back(cur_q.rd_addr, COUNT_W'(1));
							left_q <= cur_q.count - 1'b1;
							state_q <= ST_ACCUM;
						end
					endcase
				end
				ST_DROP: begin
					// The oldest total leaves the window.
					sum_q <= sum_q - ext_total(rd_data_q);
					state_q <= ST_SIGN;
				end
				ST_ACCUM: begin
					// One older total a cycle, newest first.
					sum_q <= sum_q + ext_total(rd_data_q);
					addr_q <= slot_back(addr_q, COUNT_W'(1));
					left_q <= left_q - 1'b1;
					if (left_q == COUNT_W'(1)) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					neg_q <= sum_q[SUM_W-1];
					quo_q <= sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
					rem_q <= '0;
					step_q <= STEP_W'(SUM_W);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], ge};
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Wait for the output register to be free.
					if (fin_take) begin
						mean_q <= result[VALUE_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign window_mean = mean_q;

endmodule

`default_nettype wire

// ===== rtl/trailing_moving_average.sv =====
// Trailing moving average: each result passes through the sum update, a sign split and a
// 40-step radix-2 restoring divider; a full window adds a drop step for the oldest total.
// The back handles one beat at a time while the queue holds up to two more; after a window
// size change the ring is summed again, one entry a cycle. Reset is asynchronous: the series is
// empty and window_size returns to 7; the ring is not cleared and needs no clearing pass.
// Depends on tma_pkg, tma_front, tma_queue, tma_back and trailing_moving_average_assert.svh.
`default_nettype none

module trailing_moving_average
	import tma_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [VALUE_W-1:0] day_revenue,
	input wire logic starts_series,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [VALUE_W-1:0] window_mean,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_W-1:0] cfg_data
);

	q_status_t q_status;
	item_t push_item;
	item_t head;
	logic push;
	logic pop;

	// Accepts and classifies beats.
	tma_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.day_revenue(day_revenue),
		.starts_series(starts_series),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.q_status(q_status),
		.push(push),
		.push_item(push_item)
	);

	// Holds classified beats between the two halves.
	tma_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.head(head),
		.status(q_status)
	);

	// Updates the sum, divides and delivers results.
	tma_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_status(q_status),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.window_mean(window_mean)
	);

	// Queue consistency between the front and the back.
	`include "trailing_moving_average_assert.svh"

	`TMA_ASSERT_NOW(a_pop_not_empty, pop, !q_status.empty, "queue popped while empty")
	`TMA_ASSERT_NOW(a_push_not_full, push, !q_status.full, "queue pushed while full")
	`TMA_ASSERT_NEXT(a_push_fills, push && !pop, !q_status.empty, "pushed beat missing from queue")
	`TMA_ASSERT_NEXT(a_full_holds, q_status.full && !pop, q_status.full, "full queue lost a beat")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking testbench of trailing_moving_average: directed and random daily totals,
// with expected means from a behavioral ring-and-sum model, checked beat by beat.
// Depends on tma_pkg and the trailing_moving_average RTL.
module testbench;
	import tma_pkg::*;

	localparam logic signed [VALUE_W-1:0] TOTAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] TOTAL_MIN = 32'sh8000_0000;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 60;
	localparam int PHASE_ITEMS = 80;
	localparam int RANDOM_PHASES = 13;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [VALUE_W-1:0] day_revenue;
	logic starts_series;
	logic out_valid;
	logic out_ready;
	logic signed [VALUE_W-1:0] window_mean;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	// Behavioral copy of the block state: ring of totals, series length, next slot.
	logic signed [VALUE_W-1:0] day_ring [MAX_WINDOW];
	int series_len;
	int next_slot;
	logic [CFG_W-1:0] window_setting;

	// Means still owed by the block, oldest first.
	logic signed [VALUE_W-1:0] pending_means [$];
	int mismatches = 0;
	bit idle_on = 1'b1;
	bit hold_request = 1'b0;
	int series_left = 0;

	trailing_moving_average DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.day_revenue(day_revenue),
		.starts_series(starts_series),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.window_mean(window_mean),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Takes one daily total into the model and returns the mean the block must produce.
	function automatic logic signed [VALUE_W-1:0] trailing_mean(
		input logic signed [VALUE_W-1:0] total, input logic start);
		int span;
		int k;
		longint window_total;
		if (start) begin
			series_len = 0;
			next_slot = 0;
		end
		day_ring[next_slot] = total;
		next_slot = (next_slot + 1) % MAX_WINDOW;
		if (series_len < MAX_WINDOW) begin
			series_len++;
		end
		// A zero setting acts as one, and settings past the ring depth saturate.
		span = int'(window_setting);
		if (span == 0) begin
			span = 1;
		end
		if (span > MAX_WINDOW) begin
			span = MAX_WINDOW;
		end
		if (series_len < span) begin
			span = series_len;
		end
		window_total = 0;
		for (k = 0; k < span; k++) begin
			window_total += day_ring[(next_slot + MAX_WINDOW - 1 - k) % MAX_WINDOW];
		end
		// Signed division truncates toward zero.
		return VALUE_W'(window_total / span);
	endfunction

	// Offers one beat, with an optional idle burst in front, and records its mean.
	task automatic send_day(input logic signed [VALUE_W-1:0] total, input logic start);
		logic signed [VALUE_W-1:0] owed;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		day_revenue <= total;
		starts_series <= start;
		do @(posedge clk); while (!in_ready);
		owed = trailing_mean(total, start);
		pending_means = {pending_means, owed};
	endtask

	// Writes the window size register; only called while the block is idle.
	task automatic write_window(input logic [CFG_W-1:0] setting);
		cfg_valid <= 1'b1;
		cfg_data <= setting;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		window_setting = setting;
	endtask

	// Stops offering beats and waits until every owed mean has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
	endtask

	// Mostly full-range totals, with the extremes and small values mixed in.
	function automatic logic signed [VALUE_W-1:0] random_total();
		case ($urandom_range(0, 9))
			0: return TOTAL_MAX;
			1: return TOTAL_MIN;
			2, 3, 4: return VALUE_W'($urandom_range(0, 20000) - 10000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_window();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_W'(1);
			2: return CFG_W'(MAX_WINDOW);
			3: return '1;
			4: return CFG_W'(MAX_WINDOW + 1);
			5: return CFG_W'(MAX_WINDOW - 1);
			6: return WINDOW_RESET;
			default: return CFG_W'($urandom_range(1, 64));
		endcase
	endfunction

	// Series of random length: mostly short, now and then long enough to wrap the ring.
	task automatic send_random_day();
		logic start;
		start = 1'b0;
		if (series_left == 0) begin
			start = 1'b1;
			series_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 400)
				: $urandom_range(1, 40);
		end else if ($urandom_range(0, 49) == 0) begin
			// A series cut short by an early restart.
			start = 1'b1;
		end
		series_left--;
		send_day(random_total(), start);
	endtask

	// The window size out of reset must be seven, so the mean slides after seven totals.
	task automatic test_default_window();
		int k;
		for (k = 0; k < 9; k++) begin
			send_day(VALUE_W'((k + 1) * 100), k == 0);
		end
		wait_idle();
	endtask

	// Extreme totals fill the wide sum; mixed signs check truncation toward zero.
	task automatic test_extreme_totals();
		write_window(CFG_W'(3));
		send_day(TOTAL_MAX, 1'b1);
		send_day(TOTAL_MAX, 1'b0);
		send_day(TOTAL_MAX, 1'b0);
		send_day(TOTAL_MIN, 1'b1);
		send_day(TOTAL_MIN, 1'b0);
		send_day(TOTAL_MIN, 1'b0);
		send_day(-32'sd7, 1'b1);
		send_day(32'sd2, 1'b0);
		wait_idle();
	endtask

	// A zero window acts as one; a setting past the ring depth saturates.
	task automatic test_window_bounds();
		write_window('0);
		send_day(32'sd500, 1'b0);
		send_day(-32'sd301, 1'b0);
		send_day(32'sd7, 1'b0);
		wait_idle();
		write_window('1);
		send_day(32'sd11, 1'b0);
		send_day(-32'sd5, 1'b1);
		send_day(32'sd2, 1'b0);
		wait_idle();
	endtask

	// The receiver holds off for a long stretch while beats keep coming, so the input stalls.
	task automatic test_result_stall();
		int k;
		idle_on = 1'b0;
		write_window(CFG_W'(5));
		hold_request = 1'b1;
		for (k = 0; k < 10; k++) begin
			send_day(random_total(), k == 0);
		end
		wait_idle();
		idle_on = 1'b1;
	endtask

	// Random phases, each under a new window setting, the series carried across phases.
	task automatic test_random_phases();
		int p;
		int k;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			idle_on = (p < RANDOM_PHASES - 2) && (p != 5);
			if (p == 0) begin
				write_window(CFG_W'(MAX_WINDOW));
			end else if (p == 1) begin
				write_window(CFG_W'(1));
			end else begin
				write_window(pick_window());
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				send_random_day();
			end
			wait_idle();
		end
	endtask

	// Result side: random stall bursts, and one long hold-off on request.
	initial begin : result_sink
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compares each result beat with the oldest owed mean.
	always @(posedge clk) begin : mean_check
		logic signed [VALUE_W-1:0] wanted;
		if (out_valid && out_ready) begin
			if (pending_means.size() == 0) begin
				$display("%0t: window_mean %0d arrived with nothing expected", $time,
					window_mean);
				mismatches++;
			end else begin
				wanted = pending_means.pop_front();
				if (window_mean !== wanted) begin
					$display("%0t: window_mean mismatch, expected %0d, actual %0d", $time,
						wanted, window_mean);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		#20_000_000;
		$display("trailing_moving_average test failed");
		$finish;
	end

	initial begin : run
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		day_revenue <= '0;
		starts_series <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		series_len = 0;
		next_slot = 0;
		window_setting = WINDOW_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_default_window();
		test_extreme_totals();
		test_window_bounds();
		test_result_stall();
		test_random_phases();

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_means.size() == 0) begin
			$display("trailing_moving_average test passed");
		end else begin
			$display("trailing_moving_average test failed");
		end
		$finish;
	end

endmodule
